>>> rtl/sorted_list_pool_engine_top_macros.svh
// ----------------------------------------------------------------------------
// sorted_list_pool_engine_top_macros: assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_POOL_ENGINE_TOP_MACROS_SVH
`define SORTED_LIST_POOL_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slpe assertion failed");

// Next-cycle implication, disabled during reset.
`define SLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slpe assertion failed");

`endif

>>> rtl/slpe_pkg.sv
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared types and constants of the sorted list pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

package slpe_pkg;

    localparam int SLPE_POOL_SIZE = 32;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> rtl/slpe_req_if.sv
// ----------------------------------------------------------------------------
// slpe_req_if
// Request channel: operation and value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpe_req_if
    import slpe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/slpe_rsp_if.sv
// ----------------------------------------------------------------------------
// slpe_rsp_if
// Response channel: status and slot, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpe_rsp_if
    import slpe_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_list_pool_engine_top.sv
// Insert: the list walk and the lowest free slot scan run side by side; delete walks until
//   the matching node, which it unlinks, or the end of the list.
// Throughput: one request at a time; the linked walk issues one node read per cycle through a
//   single memory read port, and an insert scans the free map one slot per cycle alongside it.
// Reset: every slot free, list empty, ready right after reset; no memory clearing pass.
// ----------------------------------------------------------------------------
// sorted_list_pool_engine_top
// Ascending sorted singly linked list kept in a pool of node slots.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_pool_engine_top
    import slpe_pkg::*;
#(
    parameter int POOL_SIZE = SLPE_POOL_SIZE
) (
    input  wire        clk,
    input  wire        rst_n,
    slpe_req_if.sink   req,
    slpe_rsp_if.source rsp
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int NW = $clog2(POOL_SIZE + 1);
    localparam logic [NW-1:0] NIL       = NW'(POOL_SIZE);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FILL,
        S_LINK,
        S_RESP
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [NW-1:0]          head_reg;
    logic [NW-1:0]          cur_reg;
    logic [NW-1:0]          prev_reg;
    logic [NW-1:0]          steps_reg;
    logic [NW-1:0]          target_reg;
    logic                   walk_busy_reg;
    logic                   scan_busy_reg;
    logic [AW-1:0]          scan_idx_reg;
    logic                   hit_reg;
    logic [AW-1:0]          slot_reg;
    status_t                status_reg;
    logic [POOL_SIZE-1:0]   free_reg;

    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic [SLOT_W-1:0]      rsp_slot_reg;

    // node storage
    logic [VALUE_W-1:0]     node_mem [POOL_SIZE];
    logic [NW-1:0]          link_mem [POOL_SIZE];
    logic [VALUE_W-1:0]     node_q_reg;
    logic [NW-1:0]          link_q_reg;

    logic [NW-1:0]          link_next;
    logic                   cur_live;
    logic [AW-1:0]          rd_addr;
    logic                   node_we;
    logic                   link_we;
    logic [AW-1:0]          link_waddr;
    logic [NW-1:0]          link_wdata;
    logic [AW+SLOT_W-1:0]   slot_ext;

    assign link_next = (link_q_reg >= NIL) ? NIL : link_q_reg;
    assign cur_live  = (cur_reg != NIL) && (steps_reg != NIL);
    assign rd_addr   = (state_reg == S_IDLE) ? head_reg[AW-1:0] : link_next[AW-1:0];

    assign node_we    = (state_reg == S_FILL);
    assign link_we    = (state_reg == S_FILL) || ((state_reg == S_LINK) && (prev_reg != NIL));
    assign link_waddr = (state_reg == S_FILL) ? slot_reg : prev_reg[AW-1:0];
    assign link_wdata = (state_reg == S_FILL) ? cur_reg : target_reg;

    // slot field is the slot index masked to its port width
    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[slot_reg] <= value_reg;
        end
        node_q_reg <= node_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            value_reg      <= '0;
            head_reg       <= NIL;
            cur_reg        <= NIL;
            prev_reg       <= NIL;
            steps_reg      <= '0;
            target_reg     <= NIL;
            walk_busy_reg  <= 1'b0;
            scan_busy_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            status_reg     <= ST_DONE;
            free_reg       <= '1;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_DONE;
            rsp_slot_reg   <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_RESP))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg        <= op_t'(req.operation);
                        value_reg     <= req.value;
                        cur_reg       <= head_reg;
                        prev_reg      <= NIL;
                        steps_reg     <= '0;
                        walk_busy_reg <= 1'b1;
                        scan_busy_reg <= (op_t'(req.operation) == OP_INSERT);
                        scan_idx_reg  <= '0;
                        hit_reg       <= 1'b0;
                        state_reg     <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    // list walk: node data for cur_reg sits in the read registers
                    if (walk_busy_reg)
                    begin
                        if (!cur_live)
                        begin
                            walk_busy_reg <= 1'b0;
                        end
                        else if (op_reg == OP_INSERT)
                        begin
                            if (node_q_reg <= value_reg)
                            begin
                                prev_reg  <= cur_reg;
                                cur_reg   <= link_next;
                                steps_reg <= steps_reg + 1'b1;
                            end
                            else
                            begin
                                walk_busy_reg <= 1'b0;
                            end
                        end
                        else if (node_q_reg == value_reg)
                        begin
                            hit_reg       <= 1'b1;
                            slot_reg      <= cur_reg[AW-1:0];
                            target_reg    <= link_next;
                            walk_busy_reg <= 1'b0;
                        end
                        else
                        begin
                            prev_reg  <= cur_reg;
                            cur_reg   <= link_next;
                            steps_reg <= steps_reg + 1'b1;
                        end
                    end

                    // lowest free slot search, runs beside the walk on inserts
                    if (scan_busy_reg)
                    begin
                        if (free_reg[scan_idx_reg])
                        begin
                            hit_reg       <= 1'b1;
                            slot_reg      <= scan_idx_reg;
                            scan_busy_reg <= 1'b0;
                        end
                        else if (scan_idx_reg == LAST_SLOT)
                        begin
                            scan_busy_reg <= 1'b0;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end

                    if (!walk_busy_reg && !scan_busy_reg)
                    begin
                        if (hit_reg)
                        begin
                            state_reg <= (op_reg == OP_INSERT) ? S_FILL : S_LINK;
                        end
                        else
                        begin
                            status_reg <= (op_reg == OP_INSERT) ? ST_FULL : ST_MISSING;
                            state_reg  <= S_RESP;
                        end
                    end
                end

                S_FILL:
                begin
                    // new node and its link written this cycle; its predecessor is pointed to it in S_LINK
                    target_reg <= NW'(slot_reg);
                    state_reg  <= S_LINK;
                end

                S_LINK:
                begin
                    if (prev_reg == NIL)
                    begin
                        head_reg <= target_reg;
                    end
                    free_reg[slot_reg] <= (op_reg == OP_DELETE);
                    status_reg         <= ST_DONE;
                    state_reg          <= S_RESP;
                end

                S_RESP:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_slot_reg   <= (status_reg == ST_DONE) ? slot_ext[SLOT_W-1:0] : '0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;

endmodule

`default_nettype wire

>>> rtl/slpe_checker.sv
// ----------------------------------------------------------------------------
// slpe_checker
// Port-level checks of the sorted list pool engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_pool_engine_top_macros.svh"

module slpe_checker
    import slpe_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                req_valid,
    input wire                req_ready,
    input wire                rsp_valid,
    input wire                rsp_ready,
    input wire [STATUS_W-1:0] rsp_status,
    input wire [SLOT_W-1:0]   rsp_slot
);

    // failed requests report slot zero
    `SLPE_ASSERT_IMPLY(a_fail_slot_zero, clk, rst_n, rsp_valid && (rsp_status != ST_DONE), rsp_slot == '0)

    // one request in flight: the engine drops ready after taking one
    `SLPE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // a response cannot appear the cycle right after a request is taken
    `SLPE_ASSERT_NEXT(a_no_instant_rsp, clk, rst_n, req_valid && req_ready, !$rose(rsp_valid))

    // a stalled response holds
    `SLPE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot))

endmodule

bind sorted_list_pool_engine_top slpe_checker u_slpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot)
);

`default_nettype wire

>>> test/tb_sorted_list_pool_engine_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_pool_engine_top
// Sorted linked list pool engine: a table of directed inserts and deletes is
// followed by fill/drain sequences with random values. Each response is
// checked against a table entry or a software copy of the list, under
// several patterns of idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_list_pool_engine_top;

    import slpe_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int NIL             = SLPE_POOL_SIZE;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int LONG_HOLD       = 150;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int SEND_IDLE [4]   = '{0, 74, 0, 11};
    localparam int RECV_STALL [4]  = '{0, 0, 74, 11};

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } rsp_expect_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic               has_want;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
    } list_case_t;

    logic clk = 1'b0;
    logic rst_n;

    slpe_req_if req_ch ();
    slpe_rsp_if rsp_ch ();

    sorted_list_pool_engine_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // software copy of the list
    logic [VALUE_W-1:0] pool_val  [SLPE_POOL_SIZE];
    int unsigned        pool_next [SLPE_POOL_SIZE];
    bit                 pool_free [SLPE_POOL_SIZE];
    int unsigned        list_head;

    rsp_expect_t slot_outcomes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_trigger   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int n_mismatch = 0;
    int n_checked  = 0;
    int n_insert   = 0;
    int n_delete   = 0;
    int n_full     = 0;
    int n_missing  = 0;

    // Directed requests. Walk from reset: empty list, extremes, duplicate
    // ordering, lowest free slot reuse, head/tail unlink, back to empty.
    list_case_t directed_cases [0:20] = '{
        '{OP_DELETE, 32'h0000_0000, 1'b1, ST_MISSING, 5'd0},
        '{OP_INSERT, 32'h8000_0000, 1'b1, ST_DONE,    5'd0},
        '{OP_INSERT, 32'h0000_0000, 1'b1, ST_DONE,    5'd1},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, ST_DONE,    5'd2},
        '{OP_INSERT, 32'h8000_0000, 1'b1, ST_DONE,    5'd3},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DONE,    5'd4},
        '{OP_DELETE, 32'h8000_0000, 1'b1, ST_DONE,    5'd0},
        '{OP_INSERT, 32'h0000_0001, 1'b1, ST_DONE,    5'd0},
        '{OP_DELETE, 32'h0000_1234, 1'b1, ST_MISSING, 5'd0},
        '{OP_DELETE, 32'hFFFF_FFFF, 1'b1, ST_DONE,    5'd2},
        '{OP_DELETE, 32'h0000_0000, 1'b1, ST_DONE,    5'd1},
        '{OP_DELETE, 32'h0000_0000, 1'b1, ST_MISSING, 5'd0},
        '{OP_INSERT, 32'h5555_5555, 1'b1, ST_DONE,    5'd1},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, ST_DONE,    5'd2},
        '{OP_DELETE, 32'h8000_0000, 1'b1, ST_DONE,    5'd3},
        '{OP_DELETE, 32'h0000_0001, 1'b1, ST_DONE,    5'd0},
        '{OP_DELETE, 32'h7FFF_FFFF, 1'b1, ST_DONE,    5'd4},
        '{OP_DELETE, 32'h5555_5555, 1'b1, ST_DONE,    5'd1},
        '{OP_DELETE, 32'hAAAA_AAAA, 1'b1, ST_DONE,    5'd2},
        '{OP_INSERT, 32'h0000_0003, 1'b0, ST_DONE,    5'd0},
        '{OP_INSERT, 32'h0000_0003, 1'b0, ST_DONE,    5'd0}
    };

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_mismatch++;
    endtask

    function automatic void clear_list();
        for (int s = 0; s < SLPE_POOL_SIZE; s++)
        begin
            pool_val[s]  = '0;
            pool_next[s] = NIL;
            pool_free[s] = 1'b1;
        end
        list_head = NIL;
    endfunction

    function automatic void relink(input int unsigned prev, input int unsigned target);
        if (prev >= NIL)
            list_head = target;
        else
            pool_next[prev] = target;
    endfunction

    function automatic void apply_list_op(input op_t op, input logic [VALUE_W-1:0] v,
                                          output status_t st, output logic [SLOT_W-1:0] sl);
        int unsigned fresh;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        bit          found;
        fresh = NIL;
        prev  = NIL;
        cur   = list_head;
        steps = 0;
        found = 1'b0;
        st    = ST_DONE;
        sl    = '0;
        if (op == OP_INSERT)
        begin
            for (int s = SLPE_POOL_SIZE - 1; s >= 0; s--)
                if (pool_free[s])
                    fresh = s;
            if (fresh == NIL)
                st = ST_FULL;
            else
            begin
                // equal values go after the ones already linked
                while (cur < NIL && steps < NIL && pool_val[cur] <= v)
                begin
                    prev = cur;
                    cur  = pool_next[cur];
                    steps++;
                end
                pool_free[fresh] = 1'b0;
                pool_val[fresh]  = v;
                pool_next[fresh] = cur;
                relink(prev, fresh);
                sl = fresh[SLOT_W-1:0];
            end
        end
        else
        begin
            while (!found && cur < NIL && steps < NIL)
            begin
                if (pool_val[cur] == v)
                begin
                    relink(prev, pool_next[cur]);
                    pool_next[cur] = NIL;
                    pool_free[cur] = 1'b1;
                    sl    = cur[SLOT_W-1:0];
                    found = 1'b1;
                end
                else
                begin
                    prev = cur;
                    cur  = pool_next[cur];
                    steps++;
                end
            end
            if (!found)
                st = ST_MISSING;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_live_value();
        int live;
        int pick;
        live = 0;
        for (int s = 0; s < SLPE_POOL_SIZE; s++)
            if (!pool_free[s])
                live++;
        if (live == 0)
            return $urandom;
        pick = $urandom_range(live - 1);
        for (int s = 0; s < SLPE_POOL_SIZE; s++)
            if (!pool_free[s])
            begin
                if (pick == 0)
                    return pool_val[s];
                pick--;
            end
        return '0;
    endfunction

    task automatic pick_request(input bit filling, output op_t op,
                                output logic [VALUE_W-1:0] v);
        int roll;
        roll = $urandom_range(99);
        op   = (roll < (filling ? 85 : 15)) ? OP_INSERT : OP_DELETE;
        roll = $urandom_range(99);
        if (op == OP_DELETE)
        begin
            if (roll < 80)
                v = random_live_value();
            else if (roll < 90)
                v = $urandom_range(15);
            else
                v = $urandom;
        end
        else if (roll < 45)
            v = $urandom_range(15);
        else if (roll < 70)
            v = $urandom;
        else if (roll < 85)
        begin
            case ($urandom_range(3))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h8000_0000;
                default: v = 32'h7FFF_FFFF;
            endcase
        end
        else
            v = random_live_value();
    endtask

    // Drives one request and returns at the edge where it is accepted; valid
    // stays high so a back-to-back request does not drop it.
    task automatic send_req(input op_t op, input logic [VALUE_W-1:0] v, input bit has_want,
                            input status_t want_status, input logic [SLOT_W-1:0] want_slot);
        status_t           st;
        logic [SLOT_W-1:0] sl;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= 1'($urandom_range(1));
            req_ch.value     <= $urandom;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_list_op(op, v, st, sl);
        if (op == OP_INSERT)
            n_insert++;
        else
            n_delete++;
        if (st == ST_FULL)
            n_full++;
        if (st == ST_MISSING)
            n_missing++;
        if (has_want)
            slot_outcomes.push_back('{want_status, want_slot});
        else
            slot_outcomes.push_back('{st, sl});
    endtask

    // response side: check, then decide ready for the next edge
    initial
    begin
        rsp_expect_t want;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (slot_outcomes.size() == 0)
                    report_mismatch($sformatf("response with none pending: status=%0d slot=%0d",
                                              rsp_ch.status, rsp_ch.slot));
                else
                begin
                    want = slot_outcomes.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d want %0d",
                                                  rsp_ch.slot, want.slot));
                    n_checked++;
                end
            end
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        op_t                op;
        logic [VALUE_W-1:0] v;
        req_ch.valid     = 1'b0;
        req_ch.operation = 1'b0;
        req_ch.value     = '0;
        rst_n            = 1'b0;
        clear_list();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            send_req(directed_cases[i].op, directed_cases[i].value, directed_cases[i].has_want,
                     directed_cases[i].status, directed_cases[i].slot);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            // long output stall while requests keep coming
            if (ph == 0 || ph == 3)
                hold_trigger <= hold_trigger + 1;
            // alternate fill-heavy and drain-heavy stretches of 50 requests
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick_request(((n / 50) % 2) == 0, op, v);
                send_req(op, v, 1'b0, ST_DONE, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (slot_outcomes.size() != 0)
            @(posedge clk);
        repeat (SLPE_POOL_SIZE + 8) @(posedge clk);

        $display("Covered %0d inserts and %0d deletes, %0d pool-full and %0d not-found outcomes.",
                 n_insert, n_delete, n_full, n_missing);
        $display("Checked %0d responses over four idle/stall mixes with long output hold-offs.",
                 n_checked);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("ERROR: run did not finish in time");
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/slpe_pkg.sv
rtl/slpe_req_if.sv
rtl/slpe_rsp_if.sv
rtl/sorted_list_pool_engine_top.sv
rtl/slpe_checker.sv
test/tb_sorted_list_pool_engine_top.sv
